>>> src/ppm_pkg.sv
package ppm_pkg;

	// bus op codes, carried on the slave tuser
	typedef enum logic [2:0] {
		OP_PIXEL     = 3'd0,
		OP_LOAD      = 3'd1,
		OP_READ      = 3'd2,
		OP_CLR_BIT   = 3'd3,
		OP_CLR_SUM   = 3'd4
	} op_t;

	localparam int OP_W       = 3;
	localparam int SPR_W      = 16;
	localparam int TILE_W     = 11;
	localparam int ADDR_W     = 7;
	localparam int WORD_W     = 4;
	localparam int COLOR_W    = 9;
	localparam int PAL_W      = 11;
	localparam int RDATA_W    = 8;
	localparam int TAB_DEPTH  = 128;
	localparam int COLL_AW    = 6;
	localparam int COLL_DEPTH = 64;

	localparam int IN_BITS    = SPR_W + 2 * TILE_W + ADDR_W + WORD_W;
	localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS   = PAL_W + RDATA_W;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	// source select codes in palette index bits 10..9
	localparam logic [1:0] SRC_SPRITE = 2'd0;
	localparam logic [1:0] SRC_FIXED  = 2'd1;
	localparam logic [1:0] SRC_SCROLL = 2'd2;

	localparam logic [5:0] READ_FILL = 6'h3f;

endpackage

>>> src/priority_pixel_mixer_with_collision.sv
// Per-pixel priority mixer. Every beat on the slave side is one op: a pixel to mix
// (sprite, fixed layer, scroll layer), a priority table load, a collision read, a
// collision bit clear or a summary clear, and each op gives exactly one result beat.
// One op is taken per clock while the master side is ready; each op passes the input
// stage, then the output register. The 128x4 priority table is read at the clock an op
// is taken; the 64-entry collision store is read and written as an op leaves the
// input stage. Entries of the priority table must be loaded before a pixel uses them.
// The collision store and summary flag clear at reset with no sweep, so the block is
// ready right after reset. cfg_we/cfg_wdata set screen_blank, which zeroes mixed pixels
// but still lets collisions be recorded; write it only while no op is in flight.
module priority_pixel_mixer_with_collision (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic                              cfg_wdata,     // screen_blank
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// sprite_pixel[15:0], fixed_pixel[26:16], scroll_pixel[37:27], address[44:38],
	// table_value[48:45], zero fill above
	input  logic [ppm_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	input  logic [ppm_pkg::OP_W-1:0]          s_axis_tuser,  // op[2:0]
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// palette_index[10:0], read_data[18:11], zero fill above
	output logic [ppm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
	import ppm_pkg::*;

	localparam int FIX_LO  = SPR_W;
	localparam int SCR_LO  = FIX_LO + TILE_W;
	localparam int ADDR_LO = SCR_LO + TILE_W;
	localparam int TVAL_LO = ADDR_LO + ADDR_W;

	// input unpack
	logic [SPR_W-1:0]  in_spr;
	logic [TILE_W-1:0] in_fix;
	logic [TILE_W-1:0] in_scr;
	logic [ADDR_W-1:0] in_addr;
	logic [WORD_W-1:0] in_tval;
	op_t               in_op;
	logic [ADDR_W-1:0] in_idx;

	assign in_spr  = s_axis_tdata[FIX_LO-1:0];
	assign in_fix  = s_axis_tdata[SCR_LO-1:FIX_LO];
	assign in_scr  = s_axis_tdata[ADDR_LO-1:SCR_LO];
	assign in_addr = s_axis_tdata[TVAL_LO-1:ADDR_LO];
	assign in_tval = s_axis_tdata[TVAL_LO+WORD_W-1:TVAL_LO];
	assign in_op   = op_t'(s_axis_tuser);

	// table index: scroll prio, scroll clear, fixed prio, fixed clear, sprite clear
	assign in_idx = {in_scr[10:9], (in_scr[2:0] == 3'd0), in_fix[10:9],
	                 (in_fix[2:0] == 3'd0), (in_spr[3:0] == 4'd0)};

	// handshake
	logic s1_vld_q;
	logic m_vld_q;
	logic out_rdy;
	logic s_acc;
	logic s1_adv;

	assign out_rdy       = !m_vld_q || m_axis_tready;
	assign s1_adv        = s1_vld_q && out_rdy;
	assign s_axis_tready = !s1_vld_q || out_rdy;
	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = m_vld_q;

	// input stage
	op_t                op_s1;
	logic [4:0]         sprid_s1;
	logic [COLOR_W-1:0] spr_col_s1;
	logic [COLOR_W-1:0] fix_col_s1;
	logic [COLOR_W-1:0] scr_col_s1;
	logic [COLL_AW-1:0] addr_s1;
	logic [WORD_W-1:0]  word_s1;

	logic [WORD_W-1:0]  tab_mem [TAB_DEPTH];

	always_ff @(posedge clk) begin
		if (s_acc && in_op == OP_LOAD) begin
			tab_mem[in_addr] <= in_tval;
		end
		if (s_acc) begin
			word_s1    <= tab_mem[in_idx];
			op_s1      <= in_op;
			sprid_s1   <= in_spr[15:11];
			spr_col_s1 <= in_spr[COLOR_W-1:0];
			fix_col_s1 <= in_fix[COLOR_W-1:0];
			scr_col_s1 <= in_scr[COLOR_W-1:0];
			addr_s1    <= in_addr[COLL_AW-1:0];
		end
	end

	// collision bookkeeping for the op leaving the input stage
	logic               hit_s1;
	logic               coll_we;
	logic               coll_wd;
	logic [COLL_AW-1:0] coll_wa;

	assign hit_s1 = (op_s1 == OP_PIXEL) && !word_s1[2];

	always_comb begin
		coll_we = 1'b0;
		coll_wd = 1'b0;
		coll_wa = addr_s1;
		if (s1_adv && hit_s1) begin
			coll_we = 1'b1;
			coll_wd = 1'b1;
			coll_wa = {word_s1[3], sprid_s1};
		end else if (s1_adv && op_s1 == OP_CLR_BIT) begin
			coll_we = 1'b1;
		end
	end

	logic                  coll_mem [COLL_DEPTH];
	logic [COLL_DEPTH-1:0] coll_vld_q;
	logic                  summary_q;
	logic                  blank_q;

	always_ff @(posedge clk) begin
		if (coll_we) begin
			coll_mem[coll_wa] <= coll_wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coll_vld_q <= '0;
			summary_q  <= 1'b0;
			blank_q    <= 1'b0;
			s1_vld_q   <= 1'b0;
			m_vld_q    <= 1'b0;
		end else begin
			if (coll_we) begin
				coll_vld_q[coll_wa] <= 1'b1;
			end
			if (s1_adv && hit_s1) begin
				summary_q <= 1'b1;
			end else if (s1_adv && op_s1 == OP_CLR_SUM) begin
				summary_q <= 1'b0;
			end
			if (cfg_we) begin
				blank_q <= cfg_wdata;
			end
			if (s_acc) begin
				s1_vld_q <= 1'b1;
			end else if (s1_adv) begin
				s1_vld_q <= 1'b0;
			end
			if (s1_adv) begin
				m_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_vld_q <= 1'b0;
			end
		end
	end

	// mixed pixel
	logic [PAL_W-1:0] pal_s1;

	always_comb begin
		pal_s1 = '0;
		if (op_s1 == OP_PIXEL && !blank_q) begin
			case (word_s1[1:0])
				SRC_SPRITE: pal_s1 = {SRC_SPRITE, spr_col_s1};
				SRC_FIXED:  pal_s1 = {SRC_FIXED, fix_col_s1};
				default:    pal_s1 = {SRC_SCROLL, scr_col_s1};
			endcase
		end
	end

	// output register; the collision store read lands here
	logic [PAL_W-1:0]   pal_q;
	logic [RDATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			pal_q <= pal_s1;
			if (op_s1 == OP_READ) begin
				rdata_q <= {summary_q, READ_FILL,
				            coll_vld_q[addr_s1] & coll_mem[addr_s1]};
			end else begin
				rdata_q <= '0;
			end
		end
	end

	assign m_axis_tdata = {{(OUT_TDATA_W-OUT_BITS){1'b0}}, rdata_q, pal_q};

	// checks
	a_one_field: assert property (@(posedge clk) disable iff (!arst_n)
		m_vld_q |-> (pal_q == '0) || (rdata_q == '0))
		else $error("pixel and read result both nonzero");

	a_read_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(m_vld_q && rdata_q != '0) |-> (rdata_q[6:1] == READ_FILL))
		else $error("read byte missing fill ones");

	a_sum_set: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && hit_s1) |=> summary_q)
		else $error("collision did not set summary");

	a_sum_clr: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && op_s1 == OP_CLR_SUM) |=> !summary_q)
		else $error("summary clear lost");

endmodule
